// File: hw/rtl/scsa_pkg.sv
// Shared types and codes for the size-class slab allocator.
// No dependencies; imported by the top level and the port checker.
package scsa_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_ZERO  = 3'd1;
  localparam status_t ST_BIG   = 3'd2;
  localparam status_t ST_NOBLK = 3'd3;
  localparam status_t ST_FULL  = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// File: hw/rtl/scsa_size_class.sv
// Maps a byte size onto its slot class, rounding up.
// Stand-alone combinational logic; used by the top level.
module scsa_size_class #(
  parameter int SLOT_STEP = 8,
  parameter int NSTEP     = 16,
  parameter int CLS_W     = 5
) (
  input  logic [7:0]       size,
  output logic [CLS_W-1:0] cls
);

  localparam int Q_W = $clog2(NSTEP + 1);

  logic [Q_W-1:0] steps;

  // Smallest multiple of the step that holds the size; compares are independent.
  always_comb begin
    steps = Q_W'(NSTEP);
    for (int j = NSTEP - 1; j >= 1; j--) begin
      if (32'(size) <= 32'(j * SLOT_STEP)) begin
        steps = Q_W'(j);
      end
    end
  end

  always_comb begin
    priority if (size == 8'd1) begin
      cls = CLS_W'(0);
    end else if (size == 8'd2) begin
      cls = CLS_W'(1);
    end else if (size <= 8'd4) begin
      cls = CLS_W'(2);
    end else begin
      cls = CLS_W'(32'(steps) + 32'd2);
    end
  end

endmodule

// File: hw/rtl/scsa_free_stack.sv
// Storage for all class free stacks, one region of FREE_DEPTH words per class.
// Synchronous single-port-read, single-port-write memory; no dependencies.
module scsa_free_stack #(
  parameter int ENTRIES = 1216,
  parameter int AW      = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data
);

  logic [15:0] mem [ENTRIES];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/scsa_class_table.sv
// Per-class bump state: current block index and byte cursor.
// Synchronous memory with a valid bit per class; unwritten classes read as "no block".
module scsa_class_table #(
  parameter int NUM_CLASSES = 19,
  parameter int CLS_W       = 5,
  parameter int CUR_W       = 11,
  parameter int BLK_W       = 6,
  parameter int BLOCK_BYTES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [CLS_W-1:0] rd_idx,
  output logic [CUR_W-1:0] rd_cur,
  output logic [BLK_W-1:0] rd_blk,
  input  logic             wr_en,
  input  logic [CLS_W-1:0] wr_idx,
  input  logic [CUR_W-1:0] wr_cur,
  input  logic [BLK_W-1:0] wr_blk
);

  localparam int EW = CUR_W + BLK_W;

  logic [EW-1:0]          mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_r;
  logic [EW-1:0]          rd_word_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_blk, wr_cur};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  // Never-written class: full cursor, block zero.
  assign rd_cur = rd_vld_r ? rd_word_r[CUR_W-1:0] : CUR_W'(BLOCK_BYTES);
  assign rd_blk = rd_vld_r ? rd_word_r[EW-1:CUR_W] : '0;

endmodule

// File: hw/rtl/size_class_slab_allocator.sv
// Size-class slab allocator with per-class LIFO free stacks and bump blocks.
// Depends on scsa_pkg, scsa_size_class, scsa_class_table and scsa_free_stack.
//
// Input channel (in_valid/in_stall): in_op selects allocate or release, in_size
// is the byte size, in_addr the slot released. Result channel
// (out_valid/out_stall): out_addr_res and out_status, one word per request.
// A request is accepted in the cycle in which the class table and the free
// stack are read; the next cycle updates them and loads the output register.
// The result is registered at the end of that update cycle, and no new request
// is taken until the update cycle is over, since both memories give a registered
// read ahead of the read-modify-write. in_stall is high in the update cycle and
// while a finished result is held by out_stall; a held result keeps its
// value. Reset empties every free stack count, marks all classes as owning
// no block, returns all blocks and drops any pending result; the block takes
// requests on the first cycle after reset. Release addresses are pushed
// unchecked; a release onto a full stack is dropped with status 4.
module size_class_slab_allocator #(
  parameter int BLOCK_BYTES = 1024,
  parameter int NUM_BLOCKS  = 64,
  parameter int FREE_DEPTH  = 64,
  parameter int SLOT_STEP   = 8,
  parameter int MAX_SLOT    = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [7:0]        in_size,
  input  logic [15:0]       in_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_addr_res,
  output scsa_pkg::status_t out_status
);

  import scsa_pkg::*;

  localparam int NSTEP       = (MAX_SLOT + SLOT_STEP - 1) / SLOT_STEP;
  localparam int NUM_CLASSES = 3 + NSTEP;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int SLOT_TOP    = NSTEP * SLOT_STEP;
  localparam int SLOT_W      = $clog2(SLOT_TOP + 1);
  localparam int CUR_TOP     = (BLOCK_BYTES > SLOT_TOP) ? BLOCK_BYTES : SLOT_TOP;
  localparam int CUR_W       = $clog2(CUR_TOP + 1);
  localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int USED_W      = $clog2(NUM_BLOCKS + 1);
  localparam int CNT_W       = $clog2(FREE_DEPTH + 1);
  localparam int FS_ENTRIES  = NUM_CLASSES * FREE_DEPTH;
  localparam int FS_AW       = (FS_ENTRIES > 1) ? $clog2(FS_ENTRIES) : 1;

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  logic              phase_r, phase_nxt;
  logic              in_acc, out_acc, exec;

  logic [CLS_W-1:0]  cls0;
  logic [CNT_W-1:0]  cnt0;
  logic [31:0]       fs_rd_sum;
  status_t           pre0;

  logic              op_r;
  logic [CLS_W-1:0]  cls_r;
  status_t           pre_r;
  logic [15:0]       addr_r;

  logic [CNT_W-1:0]  cnt_r [NUM_CLASSES];
  logic [USED_W-1:0] used_r;

  logic [CUR_W-1:0]  cur_rd;
  logic [BLK_W-1:0]  blk_rd;
  logic [15:0]       fs_rd_data;

  logic [CNT_W-1:0]  cnt1;
  logic [SLOT_W-1:0] slot1;
  logic [CUR_W:0]    fit_sum;
  logic [CUR_W-1:0]  cur_use;
  logic [BLK_W-1:0]  blk_use;
  logic [31:0]       addr_full;
  logic [31:0]       fs_wr_sum;

  status_t           status_c;
  logic [15:0]       res_c;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              cm_we;
  logic              used_inc;
  logic              fs_we;

  logic              out_valid_r;
  logic [15:0]       out_addr_res_r;
  status_t           out_status_r;

  assign in_stall = (phase_r == PH_EXEC) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign exec     = (phase_r == PH_EXEC);

  // ---- accept cycle: classify and launch memory reads ----
  scsa_size_class #(
    .SLOT_STEP(SLOT_STEP),
    .NSTEP    (NSTEP),
    .CLS_W    (CLS_W)
  ) u_size_class (
    .size(in_size),
    .cls (cls0)
  );

  assign cnt0 = cnt_r[cls0];

  // Top of stack, or the region base when empty (read result unused then).
  assign fs_rd_sum = 32'(cls0) * 32'(FREE_DEPTH) + 32'(cnt0)
                   - ((cnt0 != '0) ? 32'd1 : 32'd0);

  always_comb begin
    priority if (in_size == 8'd0) begin
      pre0 = ST_ZERO;
    end else if (32'(in_size) > 32'(MAX_SLOT)) begin
      pre0 = ST_BIG;
    end else begin
      pre0 = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      cls_r  <= cls0;
      pre_r  <= pre0;
      addr_r <= in_addr;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: if (in_acc) begin
        phase_nxt = PH_EXEC;
      end
      PH_EXEC: phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // ---- update cycle: read data is back; modify and write ----
  assign cnt1 = cnt_r[cls_r];

  always_comb begin
    unique case (cls_r)
      CLS_W'(0): slot1 = SLOT_W'(1);
      CLS_W'(1): slot1 = SLOT_W'(2);
      CLS_W'(2): slot1 = SLOT_W'(4);
      default:   slot1 = SLOT_W'((32'(cls_r) - 32'd2) * 32'(SLOT_STEP));
    endcase
  end

  assign fit_sum = {1'b0, cur_rd} + (CUR_W+1)'(slot1);

  always_comb begin
    status_c  = pre_r;
    res_c     = '0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt1;
    cm_we     = 1'b0;
    used_inc  = 1'b0;
    fs_we     = 1'b0;
    cur_use   = cur_rd;
    blk_use   = blk_rd;
    addr_full = '0;
    if (pre_r == ST_OK) begin
      if (op_r == OP_ALLOC) begin
        if (cnt1 != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt1 - CNT_W'(1);
          res_c     = fs_rd_data;
        end else if (fit_sum > (CUR_W+1)'(BLOCK_BYTES)) begin
          if (used_r >= USED_W'(NUM_BLOCKS)) begin
            status_c = ST_NOBLK;
          end else begin
            cur_use   = '0;
            blk_use   = BLK_W'(used_r);
            used_inc  = 1'b1;
            cm_we     = 1'b1;
            addr_full = 32'(blk_use) * 32'(BLOCK_BYTES) + 32'(cur_use);
            res_c     = addr_full[15:0];
          end
        end else begin
          cm_we     = 1'b1;
          addr_full = 32'(blk_use) * 32'(BLOCK_BYTES) + 32'(cur_use);
          res_c     = addr_full[15:0];
        end
      end else begin
        if (cnt1 >= CNT_W'(FREE_DEPTH)) begin
          status_c = ST_FULL;
        end else begin
          fs_we     = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = cnt1 + CNT_W'(1);
        end
      end
    end
  end

  assign fs_wr_sum = 32'(cls_r) * 32'(FREE_DEPTH) + 32'(cnt1);

  scsa_class_table #(
    .NUM_CLASSES(NUM_CLASSES),
    .CLS_W      (CLS_W),
    .CUR_W      (CUR_W),
    .BLK_W      (BLK_W),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_class_table (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .rd_idx(cls0),
    .rd_cur(cur_rd),
    .rd_blk(blk_rd),
    .wr_en (exec && cm_we),
    .wr_idx(cls_r),
    .wr_cur(CUR_W'(32'(cur_use) + 32'(slot1))),
    .wr_blk(blk_use)
  );

  scsa_free_stack #(
    .ENTRIES(FS_ENTRIES),
    .AW     (FS_AW)
  ) u_free_stack (
    .clk    (clk),
    .rd_en  (in_acc),
    .rd_addr(fs_rd_sum[FS_AW-1:0]),
    .rd_data(fs_rd_data),
    .wr_en  (exec && fs_we),
    .wr_addr(fs_wr_sum[FS_AW-1:0]),
    .wr_data(addr_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k] <= '0;
      end
      used_r <= '0;
    end else if (exec) begin
      if (cnt_we) begin
        cnt_r[cls_r] <= cnt_wdata;
      end
      if (used_inc) begin
        used_r <= used_r + USED_W'(1);
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_addr_res_r <= res_c;
      out_status_r   <= status_c;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_addr_res = out_addr_res_r;
  assign out_status   = out_status_r;

endmodule

// File: hw/rtl/scsa_checker.sv
// Port-level checks for the slab allocator, bound onto the top level.
// Depends on scsa_pkg and size_class_slab_allocator.
module scsa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [15:0]       out_addr_res,
  input scsa_pkg::status_t out_status
);

  import scsa_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_addr_res) && $stable(out_status))
    else $error("stalled result word changed");

  // Any failed request or release carries a zero address.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_addr_res == 16'd0)
    else $error("nonzero address with error status");

  // The update cycle after an accepted word blocks the input.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted during update cycle");

  // Every accepted word yields a result once its update cycle has loaded the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("result missing after accepted word");

  // Reset drops any pending result.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (.*);

// File: verif/slab_alloc_checker.sv
// Checker for the size-class slab allocator: watches the request and reply words,
// predicts each reply from its own copy of the allocator state and compares.
// Depends on scsa_pkg; instantiated by tb beside the block.
module slab_alloc_checker #(
  parameter int BLOCK_BYTES = 1024,
  parameter int NUM_BLOCKS  = 64,
  parameter int FREE_DEPTH  = 64,
  parameter int SLOT_STEP   = 8,
  parameter int MAX_SLOT    = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_op,
  input  logic [7:0]        in_size,
  input  logic [15:0]       in_addr,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [15:0]       out_addr_res,
  input  scsa_pkg::status_t out_status,
  output int                mismatches,
  output int                replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CLASSES = 3 + (MAX_SLOT + SLOT_STEP - 1) / SLOT_STEP;

  typedef struct packed {
    logic [15:0]       addr_res;
    scsa_pkg::status_t status;
  } reply_t;

  reply_t      pending_replies[$];

  logic [15:0] freed_slots [NUM_CLASSES][FREE_DEPTH];
  int unsigned freed_count [NUM_CLASSES];
  int unsigned bump_cursor [NUM_CLASSES];
  int unsigned bump_block  [NUM_CLASSES];
  int unsigned blocks_handed;

  // Round up: 1, 2 and 4 bytes, then multiples of SLOT_STEP.
  function automatic int unsigned class_of(input logic [7:0] size);
    if (size == 8'd1) return 0;
    if (size == 8'd2) return 1;
    if (size <= 8'd4) return 2;
    return 2 + (int'(size) + SLOT_STEP - 1) / SLOT_STEP;
  endfunction

  function automatic int unsigned slot_bytes(input int unsigned cls);
    if (cls == 0) return 1;
    if (cls == 1) return 2;
    if (cls == 2) return 4;
    return (cls - 2) * SLOT_STEP;
  endfunction

  function automatic reply_t serve_request(input logic op, input logic [7:0] size,
                                           input logic [15:0] addr);
    reply_t      r;
    int unsigned cls;
    int unsigned slot;
    int unsigned place;
    r.addr_res = '0;
    r.status   = scsa_pkg::ST_OK;
    if (size == 8'd0) begin
      r.status = scsa_pkg::ST_ZERO;
    end else if (int'(size) > MAX_SLOT) begin
      r.status = scsa_pkg::ST_BIG;
    end else begin
      cls = class_of(size);
      if (cls >= NUM_CLASSES) cls = NUM_CLASSES - 1;
      if (op == scsa_pkg::OP_ALLOC) begin
        if (freed_count[cls] > 0) begin
          freed_count[cls]--;
          r.addr_res = freed_slots[cls][freed_count[cls]];
        end else begin
          slot = slot_bytes(cls);
          if (bump_cursor[cls] + slot > BLOCK_BYTES && blocks_handed >= NUM_BLOCKS) begin
            r.status = scsa_pkg::ST_NOBLK;
          end else begin
            // take a fresh block when the slot no longer fits
            if (bump_cursor[cls] + slot > BLOCK_BYTES) begin
              bump_block[cls]  = blocks_handed;
              blocks_handed++;
              bump_cursor[cls] = 0;
            end
            place = bump_block[cls] * BLOCK_BYTES + bump_cursor[cls];
            r.addr_res = place[15:0];
            bump_cursor[cls] += slot;
          end
        end
      end else begin
        if (freed_count[cls] >= FREE_DEPTH) begin
          r.status = scsa_pkg::ST_FULL;
        end else begin
          freed_slots[cls][freed_count[cls]] = addr;
          freed_count[cls]++;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        freed_count[c] = 0;
        bump_cursor[c] = BLOCK_BYTES;
        bump_block[c]  = 0;
      end
      blocks_handed = 0;
      pending_replies.delete();
      mismatches = 0;
    end else begin
      // check the reply first: it always belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: reply word with none due: addr_res %h status %0d",
                   $time, out_addr_res, out_status);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (out_addr_res !== want.addr_res) begin
            $display("%0t: addr_res expected %h got %h", $time, want.addr_res, out_addr_res);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_replies.insert(pending_replies.size(),
                               serve_request(in_op, in_size, in_addr));
      end
    end
    replies_due = pending_replies.size();
  end

endmodule

// File: verif/tb.sv
// Top of the slab allocator testbench: clock, reset, request and reply stimulus.
// Depends on scsa_pkg, size_class_slab_allocator and slab_alloc_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_op     = scsa_pkg::OP_ALLOC;
  logic [7:0]        in_size   = '0;
  logic [15:0]       in_addr   = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [15:0]       out_addr_res;
  scsa_pkg::status_t out_status;

  int mismatches;
  int replies_due;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int words_sent    = 0;
  int hold_requests = 0;
  bit blocks_gone   = 1'b0;

  size_class_slab_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_size     (in_size),
    .in_addr     (in_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_addr_res(out_addr_res),
    .out_status  (out_status)
  );

  slab_alloc_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_size     (in_size),
    .in_addr     (in_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_addr_res(out_addr_res),
    .out_status  (out_status),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // note when the shared block counter has run dry, to steer the last phase
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_status == scsa_pkg::ST_NOBLK) begin
      blocks_gone <= 1'b1;
    end
  end

  initial begin : receiver
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = 80;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one request word and hold it until the block takes it.
  task automatic send_word(input logic op, input logic [7:0] size, input logic [15:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_size  <= size;
    in_addr  <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // One short sequence: mostly alloc or free bursts on one class, some noise.
  task automatic random_run();
    int         pick;
    int         len;
    logic [7:0] size;
    pick = $urandom_range(99);
    if (pick < 50) begin
      len  = $urandom_range(10, 2);
      size = ($urandom_range(99) < 60) ? 8'($urandom_range(128, 113))
                                       : 8'($urandom_range(128, 1));
      repeat (len) send_word(scsa_pkg::OP_ALLOC, size, 16'($urandom));
    end else if (pick < 80) begin
      len  = $urandom_range(8, 2);
      size = 8'($urandom_range(128, 1));
      repeat (len) send_word(scsa_pkg::OP_FREE, size, 16'($urandom));
    end else if (pick < 95) begin
      send_word(1'($urandom_range(1)), 8'($urandom_range(128, 1)), 16'($urandom));
    end else begin
      send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 16'($urandom));
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int target;
    idle_pct  = idle;
    stall_pct = stall;
    target    = words_sent + count;
    while (words_sent < target) random_run();
  endtask

  initial begin : stimulus
    int         waited;
    int         guard;
    logic [7:0] fill_size;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // size errors on both operations
    send_word(scsa_pkg::OP_ALLOC, 8'd0,   16'hFFFF);
    send_word(scsa_pkg::OP_FREE,  8'd0,   16'hFFFF);
    send_word(scsa_pkg::OP_ALLOC, 8'd129, 16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd255, 16'h0000);
    send_word(scsa_pkg::OP_FREE,  8'd255, 16'h0000);
    // class boundaries, rounding up
    send_word(scsa_pkg::OP_ALLOC, 8'd1,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd1,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd2,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd3,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd4,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd5,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd8,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd9,   16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd127, 16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd128, 16'h0000);
    // unchecked release addresses come back in LIFO order
    send_word(scsa_pkg::OP_FREE,  8'd128, 16'hFFFF);
    send_word(scsa_pkg::OP_FREE,  8'd128, 16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd128, 16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd128, 16'h0000);
    send_word(scsa_pkg::OP_ALLOC, 8'd120, 16'h0000);
    send_word(scsa_pkg::OP_FREE,  8'd1,   16'h5555);
    send_word(scsa_pkg::OP_ALLOC, 8'd1,   16'h0000);
    send_word(scsa_pkg::OP_FREE,  8'd64,  16'hAAAA);
    send_word(scsa_pkg::OP_ALLOC, 8'd57,  16'h0000);

    // hold the reply side off while overfilling one free stack
    hold_requests++;
    fill_size = 8'($urandom_range(128, 1));
    repeat (66) send_word(scsa_pkg::OP_FREE, fill_size, 16'($urandom));

    run_phase(0, 0, 40);
    run_phase(85, 0, 40);
    run_phase(0, 85, 40);
    run_phase(19, 19, 40);

    // drain the shared blocks with large slots, then keep going on an empty pool
    idle_pct  = 0;
    stall_pct = 0;
    guard     = 0;
    while (!blocks_gone && guard < 700) begin
      send_word(scsa_pkg::OP_ALLOC, 8'($urandom_range(128, 113)), 16'($urandom));
      guard++;
    end
    run_phase(19, 19, 20);

    in_valid <= 1'b0;
    waited = 0;
    while (replies_due != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && replies_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/scsa_pkg.sv
hw/rtl/scsa_size_class.sv
hw/rtl/scsa_free_stack.sv
hw/rtl/scsa_class_table.sv
hw/rtl/size_class_slab_allocator.sv
hw/rtl/scsa_checker.sv
verif/slab_alloc_checker.sv
verif/tb.sv
